// ----- hw/rtl/swrl_pkg.sv -----
// ----------------------------------------------------------------------------
// swrl_pkg
// shared types and constants of the sliding-window rate limiter
// ----------------------------------------------------------------------------
package swrl_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int SLOTS_MAX     = 64;
  localparam int CNT_W         = $clog2(SLOTS_MAX + 1);
  localparam int IDX_W         = $clog2(SLOTS_MAX);

  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 31;
  localparam int MAXC_W   = 4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1800000);
  localparam logic [MAXC_W-1:0]   MAXC_RESET   = MAXC_W'(5);

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_LOGIN   = 2'd1;
  localparam logic [1:0] OP_LOGOUT  = 2'd2;

  localparam logic [2:0] STATUS_ACCEPTED      = 3'd0;
  localparam logic [2:0] STATUS_NO_SESSION    = 3'd1;
  localparam logic [2:0] STATUS_RATE_LIMITED  = 3'd2;
  localparam logic [2:0] STATUS_DISPATCH_FAIL = 3'd3;
  localparam logic [2:0] STATUS_SESSION       = 3'd4;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_MAXC   = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] now;
    logic              has_dir;
    logic              dispatch_ok;
  } in_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] now;
    logic [CNT_W-1:0]  count;
    logic              dup;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] stamp;
  } wr_t;

endpackage

// ----- hw/rtl/swrl_cell.sv -----
// ----------------------------------------------------------------------------
// swrl_cell
// one log slot: ages out its entry as the request token passes and hands
// the running count, duplicate flag and first free slot to the next cell
// ----------------------------------------------------------------------------
module swrl_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  swrl_pkg::tok_t                     tok_in,
  output swrl_pkg::tok_t                     tok_out,
  input  logic                               clear,
  input  swrl_pkg::wr_t                      wr,
  input  logic [swrl_pkg::WINDOW_W-1:0]      window
);

  logic                          valid;
  logic [swrl_pkg::TIME_W-1:0]   stamp;
  logic [swrl_pkg::TIME_W-1:0]   age;
  logic                          expired;
  logic                          valid_next;
  swrl_pkg::tok_t                tok_next;

  assign age     = tok_in.now - stamp;
  assign expired = !age[swrl_pkg::TIME_W-1] && (age > {1'b0, window});

  always_comb begin
    valid_next = valid && !expired;
    tok_next   = tok_in;
    if (valid_next) begin
      tok_next.count = tok_in.count + swrl_pkg::CNT_W'(1);
      if (stamp == tok_in.now) begin
        tok_next.dup = 1'b1;
      end
    end else if (!tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = swrl_pkg::IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (clear) begin
        valid <= 1'b0;
      end else if (wr.en && wr.idx == swrl_pkg::IDX_W'(IDX)) begin
        valid <= 1'b1;
      end else if (tok_in.active) begin
        valid <= valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == swrl_pkg::IDX_W'(IDX)) begin
      stamp <= wr.stamp;
    end
  end

endmodule

// ----- hw/rtl/sliding_window_rate_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_unit
// sliding-window log rate limiter built as a row of slot cells
// ----------------------------------------------------------------------------
//  port group   direction  handshake           payload
//  in           input      in_valid/in_stall   in_data (swrl_pkg::in_t)
//  out          output     out_valid/out_stall out_data (swrl_pkg::out_t)
//  cfg          input      cfg_we              cfg_index, cfg_data
//
//  a request in an active session has its token registered into start_tok, the
//  token walks the row of SLOTS slot cells, then the decision and write are made
//  and the result is loaded into the output register; other items go straight to
//  the output register; in_stall stays high until the result is loaded, so a new
//  item is accepted only after the result of the last one has been loaded
//  reset empties the log, ends the session and loads the register defaults
//  a result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_unit #(
  parameter int SLOTS = swrl_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  swrl_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output swrl_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [swrl_pkg::WINDOW_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                           state;
  state_t                           state_next;
  logic [swrl_pkg::WINDOW_W-1:0]    window_ticks;
  logic [swrl_pkg::MAXC_W-1:0]      max_count;
  logic                             session_active;
  logic                             dispatch_ok;
  swrl_pkg::out_t                   res;
  swrl_pkg::tok_t                   start_tok;
  swrl_pkg::tok_t                   chain [SLOTS+1];
  swrl_pkg::tok_t                   last_tok;
  swrl_pkg::wr_t                    wr;
  logic                             accept;
  logic                             clear;
  logic                             out_free;
  logic [swrl_pkg::CNT_W-1:0]       limit;
  logic                             over;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clear    = accept && ((in_data.operation == swrl_pkg::OP_LOGIN && in_data.has_dir)
                               || in_data.operation == swrl_pkg::OP_LOGOUT);

  assign chain[0] = start_tok;
  assign last_tok = chain[SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    swrl_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[g]),
      .tok_out(chain[g+1]),
      .clear  (clear),
      .wr     (wr),
      .window (window_ticks)
    );
  end

  // limit in effect is the smaller of max_count and the slot count
  always_comb begin
    if (swrl_pkg::CNT_W'(max_count) > swrl_pkg::CNT_W'(SLOTS)) begin
      limit = swrl_pkg::CNT_W'(SLOTS);
    end else begin
      limit = swrl_pkg::CNT_W'(max_count);
    end
    over     = (last_tok.count >= limit);
    wr.en    = last_tok.active && !over && dispatch_ok && !last_tok.dup
               && last_tok.free_found;
    wr.idx   = last_tok.free_idx;
    wr.stamp = last_tok.now;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == swrl_pkg::OP_REQUEST && session_active) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (last_tok.active) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      window_ticks     <= swrl_pkg::WINDOW_RESET;
      max_count        <= swrl_pkg::MAXC_RESET;
      session_active   <= 1'b0;
      start_tok.active <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      start_tok.active <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          swrl_pkg::REG_WINDOW: window_ticks <= cfg_data;
          swrl_pkg::REG_MAXC:   max_count <= cfg_data[swrl_pkg::MAXC_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        start_tok.now        <= in_data.now;
        start_tok.count      <= '0;
        start_tok.dup        <= 1'b0;
        start_tok.free_found <= 1'b0;
        start_tok.free_idx   <= '0;
        case (in_data.operation)
          swrl_pkg::OP_LOGIN:  session_active <= in_data.has_dir;
          swrl_pkg::OP_LOGOUT: session_active <= 1'b0;
          swrl_pkg::OP_REQUEST: begin
            if (session_active) begin
              start_tok.active <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dispatch_ok          <= in_data.dispatch_ok;
      res.granted          <= 1'b0;
      if (in_data.operation == swrl_pkg::OP_REQUEST) begin
        res.status <= swrl_pkg::STATUS_NO_SESSION;
      end else begin
        res.status <= swrl_pkg::STATUS_SESSION;
      end
    end else if (state == ST_WALK && last_tok.active) begin
      if (over) begin
        res.granted <= 1'b0;
        res.status  <= swrl_pkg::STATUS_RATE_LIMITED;
      end else if (!dispatch_ok) begin
        res.granted <= 1'b0;
        res.status  <= swrl_pkg::STATUS_DISPATCH_FAIL;
      end else begin
        res.granted <= 1'b1;
        res.status  <= swrl_pkg::STATUS_ACCEPTED;
      end
    end
    if (state == ST_DONE && out_free) begin
      out_data <= res;
    end
  end

endmodule

// ----- dv/sliding_window_rate_limiter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_unit_test
// self-checking bench for the sliding-window log rate limiter: a scripted
// opening run over session events, duplicates, wrap and dispatch failure, then
// random session traffic under nine register settings, each result checked
// against a scripted verdict or an in-bench model of the grant log
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_unit_test;
  import swrl_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t verdict;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_WINDOW;
  logic [WINDOW_W-1:0] cfg_data = '0;

  // model of the grant log
  logic [TIME_W-1:0] log_stamp[SLOTS];
  bit log_live[SLOTS];
  bit in_session;
  logic [WINDOW_W-1:0] win_ticks;
  logic [MAXC_W-1:0] grant_cap;

  out_t verdicts_due[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_tally[5];
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  bit [TIME_W-1:0] tick;

  sliding_window_rate_limiter_unit #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_t rate_verdict(input in_t it);
    out_t v;
    int live_cnt;
    int free_idx;
    int cap;
    bit dup;
    logic [TIME_W-1:0] age;
    v.granted = 1'b0;
    v.status = STATUS_SESSION;
    case (it.operation)
      OP_LOGIN: begin
        if (it.has_dir) begin
          in_session = 1'b1;
          log_live = '{default: 1'b0};
        end else begin
          in_session = 1'b0;
        end
      end
      OP_LOGOUT: begin
        in_session = 1'b0;
        log_live = '{default: 1'b0};
      end
      OP_REQUEST: begin
        if (!in_session) begin
          v.status = STATUS_NO_SESSION;
        end else begin
          live_cnt = 0;
          free_idx = -1;
          dup = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (log_live[i]) begin
              age = it.now - log_stamp[i];
              // negative age never expires
              if (!age[TIME_W-1] && age > {1'b0, win_ticks}) log_live[i] = 1'b0;
            end
            if (log_live[i]) begin
              live_cnt++;
              if (log_stamp[i] == it.now) dup = 1'b1;
            end else if (free_idx < 0) begin
              free_idx = i;
            end
          end
          cap = (grant_cap < SLOTS) ? int'(grant_cap) : SLOTS;
          if (live_cnt >= cap) begin
            v.status = STATUS_RATE_LIMITED;
          end else if (!it.dispatch_ok) begin
            v.status = STATUS_DISPATCH_FAIL;
          end else begin
            if (!dup && free_idx >= 0) begin
              log_stamp[free_idx] = it.now;
              log_live[free_idx] = 1'b1;
            end
            v.granted = 1'b1;
            v.status = STATUS_ACCEPTED;
          end
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t next_item();
    in_t it;
    int r;
    bit [TIME_W-1:0] span;
    span = (win_ticks == 0) ? 32'd2 : {1'b0, win_ticks};
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // same time again, a duplicate stamp
    end else if (r < 70) begin
      tick += $urandom_range(1, span / 3 + 1);
    end else if (r < 88) begin
      tick += $urandom_range(span / 2, span + span / 2);
    end else if (r < 95) begin
      tick -= $urandom_range(0, span);
    end else begin
      tick = $urandom();
    end
    it.now = tick;
    it.has_dir = 1'($urandom_range(0, 1));
    it.dispatch_ok = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 99);
    if (!in_session) begin
      if (r < 75) begin
        it.operation = OP_LOGIN;
        it.has_dir = 1'b1;
      end else if (r < 85) begin
        it.operation = OP_REQUEST;
      end else if (r < 92) begin
        it.operation = OP_LOGOUT;
      end else if (r < 96) begin
        it.operation = OP_LOGIN;
        it.has_dir = 1'b0;
      end else begin
        it.operation = OP_UNUSED;
      end
    end else begin
      if (r < 86) begin
        it.operation = OP_REQUEST;
      end else if (r < 90) begin
        it.operation = OP_LOGOUT;
      end else if (r < 93) begin
        it.operation = OP_LOGIN;
        it.has_dir = 1'b1;
      end else if (r < 96) begin
        it.operation = OP_LOGIN;
        it.has_dir = 1'b0;
      end else begin
        it.operation = OP_UNUSED;
      end
    end
    return it;
  endfunction

  function automatic script_row_t step_row(logic [1:0] op, logic [TIME_W-1:0] t,
                                           logic dir, logic disp, bit typed,
                                           logic g, logic [2:0] st);
    script_row_t row;
    row.item.operation = op;
    row.item.now = t;
    row.item.has_dir = dir;
    row.item.dispatch_ok = disp;
    row.typed = typed;
    row.verdict.granted = g;
    row.verdict.status = st;
    return row;
  endfunction

  task automatic offer_item(input in_t it, input bit typed, input out_t typed_verdict);
    int gap;
    out_t v;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    v = rate_verdict(it);
    if (typed) v = typed_verdict;
    verdicts_due.push_back(v);
    status_tally[v.status]++;
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [WINDOW_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW) win_ticks = val;
    else grant_cap = val[MAXC_W-1:0];
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // receiver side: random back-pressure plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        note_mismatch($sformatf("result granted %0d status %0d with nothing pending",
                                out_data.granted, out_data.status));
      end else begin
        exp_v = verdicts_due.pop_front();
        if (out_data.granted !== exp_v.granted)
          note_mismatch($sformatf("result %0d granted: want %0d got %0d",
                                  results_seen, exp_v.granted, out_data.granted));
        if (out_data.status !== exp_v.status)
          note_mismatch($sformatf("result %0d status: want %0d got %0d",
                                  results_seen, exp_v.status, out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results pending",
                 QUIET_LIMIT, verdicts_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    script_row_t script[$];
    logic [WINDOW_W-1:0] phase_window[PHASES];
    logic [MAXC_W-1:0] phase_cap[PHASES];
    out_t none;
    none = '0;
    phase_window = '{WINDOW_RESET, 31'd100, 31'd0, 31'd1, 31'h7FFF_FFFF,
                     31'd1000, 31'd37, 31'd5000, 31'd250};
    phase_cap = '{MAXC_RESET, 4'd3, 4'd2, 4'd8, 4'd15, 4'd0, 4'd9, 4'd1, 4'd5};

    win_ticks = WINDOW_RESET;
    grant_cap = MAXC_RESET;
    in_session = 1'b0;
    log_live = '{default: 1'b0};
    status_tally = '{default: 0};

    script.push_back(step_row(OP_REQUEST, 32'd0, 1'b0, 1'b1, 1, 1'b0, STATUS_NO_SESSION));
    script.push_back(step_row(OP_UNUSED, 32'd7, 1'b1, 1'b1, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_LOGOUT, 32'd0, 1'b0, 1'b0, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_LOGIN, 32'd0, 1'b0, 1'b0, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_REQUEST, 32'd3, 1'b0, 1'b1, 1, 1'b0, STATUS_NO_SESSION));
    script.push_back(step_row(OP_LOGIN, 32'd0, 1'b1, 1'b0, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_REQUEST, 32'd0, 1'b0, 1'b1, 1, 1'b1, STATUS_ACCEPTED));
    // same stamp again: granted but not logged
    script.push_back(step_row(OP_REQUEST, 32'd0, 1'b0, 1'b1, 1, 1'b1, STATUS_ACCEPTED));
    script.push_back(step_row(OP_REQUEST, 32'd5, 1'b0, 1'b0, 1, 1'b0,
                              STATUS_DISPATCH_FAIL));
    script.push_back(step_row(OP_REQUEST, 32'hFFFF_FFFF, 1'b1, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'd1800000, 1'b0, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'd1800001, 1'b0, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'd1800002, 1'b0, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'd1800003, 1'b0, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'd1800004, 1'b0, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'd1800005, 1'b0, 1'b0, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'h7FFF_FFFF, 1'b0, 1'b1, 0, 1'b0, '0));
    script.push_back(step_row(OP_REQUEST, 32'h8000_0000, 1'b0, 1'b1, 0, 1'b0, '0));
    // login without a directory keeps the log but ends the session
    script.push_back(step_row(OP_LOGIN, 32'd9, 1'b0, 1'b1, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_REQUEST, 32'h8000_0001, 1'b0, 1'b1, 1, 1'b0,
                              STATUS_NO_SESSION));
    script.push_back(step_row(OP_LOGIN, 32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_REQUEST, 32'h8000_0000, 1'b1, 1'b1, 1, 1'b1,
                              STATUS_ACCEPTED));
    script.push_back(step_row(OP_LOGOUT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, STATUS_SESSION));
    script.push_back(step_row(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, STATUS_SESSION));

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer_item(script[i].item, script[i].typed, script[i].verdict);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        set_register(REG_WINDOW, phase_window[p]);
        set_register(REG_MAXC, WINDOW_W'(phase_cap[p]));
      end
      calm = (p == 2 || p == 6);
      tick = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 20) hold_request = 1'b1;
        offer_item(next_item(), 0, none);
      end
      drain_results();
    end

    repeat (4 * SLOTS + 20) @(posedge clk);
    $display("covered %0d items over %0d register settings, %0d results checked",
             items_sent, PHASES, results_seen);
    $display("  granted %0d, rate limited %0d, no session %0d, dispatch failed %0d",
             status_tally[STATUS_ACCEPTED], status_tally[STATUS_RATE_LIMITED],
             status_tally[STATUS_NO_SESSION], status_tally[STATUS_DISPATCH_FAIL]);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/swrl_pkg.sv
hw/rtl/swrl_cell.sv
hw/rtl/sliding_window_rate_limiter_unit.sv
dv/sliding_window_rate_limiter_unit_test.sv
